>>> hw/rtl/tsrf_pkg.sv
// ----------------------------------------------------------------------------
// tsrf_pkg: shared types and constants for the timed source report filter
// Holds the control word layout, the microcode store and the result codes.
// ----------------------------------------------------------------------------
package tsrf_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned TIME_W    = 31;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned STEP_W    = 2;

  localparam logic [TIME_W-1:0] HOLDOFF_RESET = 31'd10000;

  // result codes
  localparam logic [OUTCOME_W-1:0] OUTCOME_REFRESH = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_NEW     = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_FULL    = 2'd2;

  typedef logic [STEP_W-1:0] step_t;

  // microcode addresses
  localparam step_t STEP_LOAD   = 2'd0;
  localparam step_t STEP_SCAN   = 2'd1;
  localparam step_t STEP_COMMIT = 2'd2;
  localparam step_t STEP_EMIT   = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SCAN   = 2'd1,
    OP_COMMIT = 2'd2,
    OP_EMIT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    COND_NONE      = 2'd0,
    COND_NO_INPUT  = 2'd1,
    COND_SCAN_MORE = 2'd2,
    COND_OUT_BUSY  = 2'd3
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump;
    step_t nxt;
  } cw_t;

  typedef struct packed {
    logic no_input;
    logic scan_more;
    logic out_busy;
  } seq_flags_t;

  // microcode store: jump taken when the condition holds, else fall to nxt
  function automatic cw_t rom_word(step_t step);
    cw_t cw;
    unique case (step)
      STEP_LOAD:   cw = '{op: OP_LOAD,   cond: COND_NO_INPUT,  jump: STEP_LOAD,
                          nxt: STEP_SCAN};
      STEP_SCAN:   cw = '{op: OP_SCAN,   cond: COND_SCAN_MORE, jump: STEP_SCAN,
                          nxt: STEP_COMMIT};
      STEP_COMMIT: cw = '{op: OP_COMMIT, cond: COND_NONE,      jump: STEP_COMMIT,
                          nxt: STEP_EMIT};
      STEP_EMIT:   cw = '{op: OP_EMIT,   cond: COND_OUT_BUSY,  jump: STEP_EMIT,
                          nxt: STEP_LOAD};
      default:     cw = '{op: OP_LOAD,   cond: COND_NONE,      jump: STEP_LOAD,
                          nxt: STEP_LOAD};
    endcase
    return cw;
  endfunction

endpackage

>>> hw/rtl/timed_source_report_filter.sv
// ----------------------------------------------------------------------------
// timed_source_report_filter: repeat-attempt suppression table
// Decides per connection attempt whether it is announced, refreshing or
// storing source entries in a small address/time table.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries one word per attempt:
//   source_address and now_ms. output channel (out_valid/out_ready) returns
//   one word per attempt: report and outcome (refresh, new, full).
//   cfg_we/cfg_data writes holdoff_ms; write it only while the block is idle.
// timing
//   a microcoded sequencer walks the table one entry per cycle through the
//   single read port of the entry memory: 1 load step, up to ENTRIES scan
//   steps (stops at the first address match), 1 commit step, 1 emit step.
//   the emit step writes the result into the output register, and a new word
//   is taken only in the load step that follows the emit step.
// reset
//   rst clears the sequencer, the per-entry valid bits (the table reads as
//   all zero), out_valid of the output register and sets holdoff_ms to 10000.
// stall
//   the result sits in an output register; the next word can be accepted
//   and scanned while it waits, and the emit step waits until it is free.
// ----------------------------------------------------------------------------
module timed_source_report_filter #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tsrf_pkg::TIME_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tsrf_pkg::ADDR_W-1:0]      source_address,
  input  logic [tsrf_pkg::TIME_W-1:0]      now_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             report,
  output logic [tsrf_pkg::OUTCOME_W-1:0]   outcome
);
  import tsrf_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // sequencer interface
  cw_t        cw;
  seq_flags_t flags;

  // configuration
  logic [TIME_W-1:0] holdoff;

  // entry memory, valid bits stand in for the cleared reset state
  logic [ADDR_W-1:0] addr_mem [ENTRIES];
  logic [TIME_W-1:0] time_mem [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;

  // read port
  logic [IDX_W-1:0]  rd_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic [TIME_W-1:0] rd_time;
  logic              rd_valid;
  logic [ADDR_W-1:0] cur_addr;
  logic [TIME_W-1:0] cur_time;

  // write port
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;

  // working registers of the current word
  logic [ADDR_W-1:0]    addr_q;
  logic [TIME_W-1:0]    now_q;
  logic [IDX_W-1:0]     idx;
  logic                 hit;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic                 res_report;
  logic [OUTCOME_W-1:0] res_outcome;

  // decoded datapath conditions
  logic              accept;
  logic              match;
  logic              expired;
  logic [TIME_W:0]   limit;
  logic              out_busy;
  logic              emit;

  tsrf_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  assign in_ready = (cw.op == OP_LOAD);
  assign accept   = in_valid && in_ready;
  assign out_busy = out_valid && !out_ready;
  assign emit     = (cw.op == OP_EMIT) && !out_busy;

  // entries that were never written read as address zero, time zero
  assign cur_addr = rd_valid ? rd_addr : '0;
  assign cur_time = rd_valid ? rd_time : '0;

  // expiry: stamp + holdoff strictly below now, one bit wider so no wrap
  assign limit   = {1'b0, cur_time} + {1'b0, holdoff};
  assign expired = limit < {1'b0, now_q};
  assign match   = (cur_addr == addr_q);

  assign flags.no_input  = !in_valid;
  assign flags.scan_more = !(match || (idx == LAST_IDX));
  assign flags.out_busy  = out_busy;

  // read one entry ahead of the compare
  always_comb begin
    rd_idx = '0;
    if (cw.op == OP_SCAN && idx != LAST_IDX) begin
      rd_idx = idx + 1'b1;
    end else if (cw.op == OP_SCAN) begin
      rd_idx = idx;
    end
  end

  // refresh of a hit, or placement of a new source
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = idx;
    if (cw.op == OP_SCAN && match) begin
      wr_en  = 1'b1;
      wr_idx = idx;
    end else if (cw.op == OP_COMMIT && !hit && free_found) begin
      wr_en  = 1'b1;
      wr_idx = free_idx;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr  <= addr_mem[rd_idx];
    rd_time  <= time_mem[rd_idx];
    rd_valid <= entry_valid[rd_idx];
    if (wr_en) begin
      addr_mem[wr_idx] <= addr_q;
      time_mem[wr_idx] <= now_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      holdoff     <= HOLDOFF_RESET;
    end else begin
      if (wr_en) begin
        entry_valid[wr_idx] <= 1'b1;
      end
      if (cfg_we) begin
        holdoff <= cfg_data;
      end
    end
  end

  // per-word scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      case (cw.op)
        OP_LOAD: begin
          if (accept) begin
            hit        <= 1'b0;
            free_found <= 1'b0;
          end
        end
        OP_SCAN: begin
          if (match) begin
            hit <= 1'b1;
          end else if (cur_addr == '0 || expired) begin
            free_found <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers of the current word
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (accept) begin
          addr_q <= source_address;
          now_q  <= now_ms;
          idx    <= '0;
        end
      end
      OP_SCAN: begin
        if (match) begin
          res_report  <= expired;
          res_outcome <= OUTCOME_REFRESH;
        end else begin
          if (cur_addr == '0 || expired) begin
            free_idx <= idx;
          end
          if (idx != LAST_IDX) begin
            idx <= idx + 1'b1;
          end
        end
      end
      OP_COMMIT: begin
        if (!hit) begin
          res_report  <= free_found;
          res_outcome <= free_found ? OUTCOME_NEW : OUTCOME_FULL;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      report  <= res_report;
      outcome <= res_outcome;
    end
  end

endmodule

>>> hw/rtl/tsrf_seq.sv
// ----------------------------------------------------------------------------
// tsrf_seq: microcode sequencer
// Step counter over the control store, with a conditional jump per step.
// ----------------------------------------------------------------------------
module tsrf_seq (
  input  logic                clk,
  input  logic                rst,
  input  tsrf_pkg::seq_flags_t flags,
  output tsrf_pkg::cw_t       cw
);
  import tsrf_pkg::*;

  step_t step;
  step_t step_next;
  logic  taken;

  assign cw = rom_word(step);

  always_comb begin
    unique case (cw.cond)
      COND_NONE:      taken = 1'b0;
      COND_NO_INPUT:  taken = flags.no_input;
      COND_SCAN_MORE: taken = flags.scan_more;
      COND_OUT_BUSY:  taken = flags.out_busy;
      default:        taken = 1'b0;
    endcase
    step_next = taken ? cw.jump : cw.nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_LOAD;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> hw/rtl/tsrf_chk.sv
// ----------------------------------------------------------------------------
// tsrf_chk: port-level checks for the timed source report filter
// Watches the top level's ports and flags inconsistent results.
// ----------------------------------------------------------------------------
module tsrf_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           report,
  input logic [tsrf_pkg::OUTCOME_W-1:0] outcome
);
  import tsrf_pkg::*;

  // only the three defined result codes appear
  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (outcome == OUTCOME_REFRESH || outcome == OUTCOME_NEW ||
                   outcome == OUTCOME_FULL))
    else $error("undefined outcome code");

  // a dropped attempt is never announced
  a_full_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outcome == OUTCOME_FULL) |-> !report)
    else $error("report raised on full table");

  // a newly stored source is always announced
  a_new_reports: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outcome == OUTCOME_NEW) |-> report)
    else $error("new entry without report");

  // one word in flight: intake closes right after a word is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken during scan");

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result visible after reset");

endmodule

bind timed_source_report_filter tsrf_chk u_tsrf_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .report    (report),
  .outcome   (outcome)
);
